>>> rtl/pidc_pkg.sv
// Package: shared constants and widths for the clamped PID controller.
package pidc_pkg;

   // Fixed-point format and field widths
   localparam int FRAC_BITS   = 8;
   localparam int TICK_WIDTH  = 32;
   localparam int ANGLE_W     = 16;
   localparam int GAIN_W      = 16;
   localparam int DRIVE_W     = 8;
   localparam int MAG_W       = ANGLE_W;
   localparam int MUL_W       = 32;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int DIV_W       = 32;
   localparam int DIV_CNT_W   = $clog2(DIV_W);

   // Drive limit in whole units
   localparam int LIMIT_WHOLE = 100;

   // Integral: FRAC_BITS fractional bits, always within the limit
   localparam int INT_W = FRAC_BITS + 8;
   // Capped increment magnitude, 2*FRAC_BITS fractional bits
   localparam int INC_W = 2 * FRAC_BITS + 8;
   // Integral accumulator before clamping
   localparam int ACC_W = 2 * FRAC_BITS + 10;
   // Drive sum before clamping; the gain products alone reach 33 bits
   localparam int PID_W = (2 * FRAC_BITS + 20 > 36) ? 2 * FRAC_BITS + 20 : 36;
   localparam int WHOLE_W = 7;

   localparam logic [INC_W-1:0] INC_CAP =
      INC_W'(2 * LIMIT_WHOLE + 1) << (2 * FRAC_BITS);
   localparam logic signed [ACC_W-1:0] ACC_LIMIT =
      ACC_W'(LIMIT_WHOLE) << (2 * FRAC_BITS);
   localparam logic signed [PID_W-1:0] PID_LIMIT =
      PID_W'(LIMIT_WHOLE) << (2 * FRAC_BITS);

   // Register map
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D = 2'd2;

   localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd1280;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET = 16'd1792;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = 16'd179;

endpackage

>>> rtl/pidc_req_if.sv
// Interface: request channel carrying setpoint, measured angle and tick.
interface pidc_req_if;
   import pidc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_W-1:0]    setpoint;
   logic signed [ANGLE_W-1:0]    measured;
   logic        [TICK_WIDTH-1:0] now_tick;

   modport source (output valid, output setpoint, output measured, output now_tick,
                   input ready);
   modport sink   (input valid, input setpoint, input measured, input now_tick,
                   output ready);
endinterface

>>> rtl/pidc_rsp_if.sv
// Interface: response channel carrying the drive value and saturation flag.
interface pidc_rsp_if;
   import pidc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic                      saturated;

   modport source (output valid, output drive, output saturated, input ready);
   modport sink   (input valid, input drive, input saturated, output ready);
endinterface

>>> rtl/pidc_divider.sv
// Module: restoring unsigned divider, one quotient bit per cycle.
module pidc_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pidc_pkg::DIV_W-1:0]  dividend,
   input  logic [pidc_pkg::DIV_W-1:0]  divisor,
   output logic                        done,
   output logic [pidc_pkg::DIV_W-1:0]  quotient
);
   import pidc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     den_ff, den_in;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       trial;

   always_comb begin
      shifted  = {rem_ff, quo_ff[DIV_W-1]};
      trial    = shifted - {1'b0, den_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         den_in   = divisor;
      end else if (busy_ff) begin
         // subtract when the shifted remainder covers the divisor
         if (!trial[DIV_W]) begin
            rem_in = trial[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIV_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/pid_controller_clamped_unit.sv
// Top level: clamped PID controller, derivative on measurement, shared-unit sequencer.
//
// Usage:
//  - req_chan brings setpoint and measured angle (signed Q8.8) and a millisecond
//    tick; a transfer happens at a rising edge with valid and ready both high.
//  - rsp_chan returns one drive value (-100..100, truncated toward zero) and a
//    saturation flag for every request transfer, in order.
//  - csr_write_en/csr_index/csr_data write gain_p (0), gain_i (1), gain_d (2),
//    unsigned Q8.8; other indexes are dropped. Write only while idle.
//  - One item at a time: a 32x32 multiplier is shared over four products under
//    the sequencer, and a bit-serial divider forms the derivative quotient.
//    The item passes the multiplies, the integral update and the divider
//    (skipped when the elapsed tick count is zero) into the result register;
//    req ready returns at the same edge that loads the result register.
//  - The result register parts the two sides: if the receiver stalls, the
//    finished result holds there and the next request is still taken; a second
//    result then waits in the final step until the register frees.
//  - Reset (synchronous, active high) restores default gains and clears the
//    integral, previous measured angle and previous tick.
module pid_controller_clamped_unit (
   input  logic                                clock,
   input  logic                                reset,
   pidc_req_if.sink                            req_chan,
   pidc_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_en,
   input  logic [pidc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pidc_pkg::GAIN_W-1:0]         csr_data
);
   import pidc_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_MUL_I1    = 9'b000000010,
      ST_MUL_I2    = 9'b000000100,
      ST_INTEG     = 9'b000001000,
      ST_MUL_D     = 9'b000010000,
      ST_DIV_START = 9'b000100000,
      ST_DIV_WAIT  = 9'b001000000,
      ST_MUL_P     = 9'b010000000,
      ST_FINISH    = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Gains
   logic [GAIN_W-1:0] gain_p_ff, gain_p_in;
   logic [GAIN_W-1:0] gain_i_ff, gain_i_in;
   logic [GAIN_W-1:0] gain_d_ff, gain_d_in;

   // Loop state
   logic signed [INT_W-1:0]   integral_ff, integral_in;
   logic signed [ANGLE_W-1:0] prev_meas_ff, prev_meas_in;
   logic [TICK_WIDTH-1:0]     prev_tick_ff, prev_tick_in;

   // Per-item operands
   logic              err_neg_ff, err_neg_in;
   logic [MAG_W-1:0]  err_mag_ff, err_mag_in;
   logic              diff_neg_ff, diff_neg_in;
   logic [MAG_W-1:0]  diff_mag_ff, diff_mag_in;
   logic [TICK_WIDTH-1:0] dt_ff, dt_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIV_W-1:0]  dmag_ff, dmag_in;

   // Result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;
   logic                      rsp_sat_ff, rsp_sat_in;

   logic req_xfer;
   logic rsp_free;

   // Shared multiplier
   logic [MUL_W-1:0]  mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;
   logic [MUL_W-1:0]  dt_wide;

   // Divider hookup
   logic             div_start;
   logic             div_done;
   logic [DIV_W-1:0] div_quotient;

   // Arithmetic on the item
   logic signed [ANGLE_W:0]  err_full, diff_full;
   logic [INC_W-1:0]         inc_mag;
   logic signed [ACC_W-1:0]  inc_s, int_scaled, acc, acc_cl;
   logic [ACC_W-1:0]         acc_mag;
   logic [INT_W-1:0]         int_mag;
   logic signed [PID_W-1:0]  pterm, dterm, int_pid, pid, pid_cl;
   logic [PID_W-1:0]         pid_mag;
   logic [WHOLE_W-1:0]       whole;
   logic                     pid_sat;

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign dt_wide  = MUL_W'(dt_ff);

   pidc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff[DIV_W-1:0]),
      .divisor  (DIV_W'(dt_ff)),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_I1: begin
            mul_a = MUL_W'(gain_i_ff);
            mul_b = MUL_W'(err_mag_ff);
         end
         ST_MUL_I2: begin
            mul_a = prod_ff[MUL_W-1:0];
            mul_b = dt_wide;
         end
         ST_MUL_D: begin
            mul_a = MUL_W'(gain_d_ff);
            mul_b = MUL_W'(diff_mag_ff);
         end
         ST_MUL_P: begin
            mul_a = MUL_W'(gain_p_ff);
            mul_b = MUL_W'(err_mag_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Integral update: capped increment, clamp, truncate toward zero
   always_comb begin
      inc_mag    = (prod_ff > PROD_W'(INC_CAP)) ? INC_CAP : prod_ff[INC_W-1:0];
      inc_s      = $signed(ACC_W'(inc_mag));
      int_scaled = ACC_W'(integral_ff) <<< FRAC_BITS;
      acc        = int_scaled + (err_neg_ff ? -inc_s : inc_s);
      if (acc > ACC_LIMIT) begin
         acc_cl = ACC_LIMIT;
      end else if (acc < -ACC_LIMIT) begin
         acc_cl = -ACC_LIMIT;
      end else begin
         acc_cl = acc;
      end
      acc_mag = acc_cl[ACC_W-1] ? ACC_W'(-acc_cl) : ACC_W'(acc_cl);
      int_mag = INT_W'(acc_mag >> FRAC_BITS);
   end

   // Drive sum: p + integral - derivative, clamp, truncate to whole units
   always_comb begin
      pterm   = $signed(PID_W'(prod_ff[MUL_W-1:0]));
      dterm   = $signed(PID_W'(dmag_ff));
      int_pid = PID_W'(integral_ff) <<< FRAC_BITS;
      pid     = (err_neg_ff ? -pterm : pterm) + int_pid - (diff_neg_ff ? -dterm : dterm);
      pid_sat = 1'b0;
      if (pid > PID_LIMIT) begin
         pid_cl  = PID_LIMIT;
         pid_sat = 1'b1;
      end else if (pid < -PID_LIMIT) begin
         pid_cl  = -PID_LIMIT;
         pid_sat = 1'b1;
      end else begin
         pid_cl = pid;
      end
      pid_mag = pid_cl[PID_W-1] ? PID_W'(-pid_cl) : PID_W'(pid_cl);
      whole   = pid_mag[2*FRAC_BITS +: WHOLE_W];
   end

   // Sequencer and datapath registers
   always_comb begin
      err_full  = ANGLE_W'(0) + ((ANGLE_W+1)'(req_chan.setpoint) -
                                 (ANGLE_W+1)'(req_chan.measured));
      diff_full = (ANGLE_W+1)'(req_chan.measured) - (ANGLE_W+1)'(prev_meas_ff);

      state_in     = state_ff;
      gain_p_in    = gain_p_ff;
      gain_i_in    = gain_i_ff;
      gain_d_in    = gain_d_ff;
      integral_in  = integral_ff;
      prev_meas_in = prev_meas_ff;
      prev_tick_in = prev_tick_ff;
      err_neg_in   = err_neg_ff;
      err_mag_in   = err_mag_ff;
      diff_neg_in  = diff_neg_ff;
      diff_mag_in  = diff_mag_ff;
      dt_in        = dt_ff;
      prod_in      = prod_ff;
      dmag_in      = dmag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_sat_in   = rsp_sat_ff;
      div_start    = 1'b0;

      // drop the result once the receiver takes it
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // register writes; unknown indexes are dropped
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GAIN_P: gain_p_in = csr_data;
            CSR_GAIN_I: gain_i_in = csr_data;
            CSR_GAIN_D: gain_d_in = csr_data;
            default:    ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               err_neg_in   = err_full[ANGLE_W];
               err_mag_in   = err_full[ANGLE_W] ? MAG_W'(-err_full) : MAG_W'(err_full);
               diff_neg_in  = diff_full[ANGLE_W];
               diff_mag_in  = diff_full[ANGLE_W] ? MAG_W'(-diff_full) : MAG_W'(diff_full);
               dt_in        = req_chan.now_tick - prev_tick_ff;
               prev_meas_in = req_chan.measured;
               prev_tick_in = req_chan.now_tick;
               state_in     = ST_MUL_I1;
            end
         end
         ST_MUL_I1: begin
            prod_in  = mul_p;
            state_in = ST_MUL_I2;
         end
         ST_MUL_I2: begin
            prod_in  = mul_p;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            integral_in = acc_cl[ACC_W-1] ? INT_W'(-int_mag) : INT_W'(int_mag);
            state_in    = ST_MUL_D;
         end
         ST_MUL_D: begin
            prod_in  = mul_p;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            // no elapsed time: derivative is zero, skip the divider
            if (dt_ff == '0) begin
               dmag_in  = '0;
               state_in = ST_MUL_P;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               dmag_in  = div_quotient;
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            prod_in  = mul_p;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold here until the result register frees
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_drive_in = pid_cl[PID_W-1] ? DRIVE_W'(-{1'b0, whole})
                                              : DRIVE_W'({1'b0, whole});
               rsp_sat_in   = pid_sat;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_p_ff    <= GAIN_P_RESET;
         gain_i_ff    <= GAIN_I_RESET;
         gain_d_ff    <= GAIN_D_RESET;
         integral_ff  <= '0;
         prev_meas_ff <= '0;
         prev_tick_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         integral_ff  <= integral_in;
         prev_meas_ff <= prev_meas_in;
         prev_tick_ff <= prev_tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      err_neg_ff   <= err_neg_in;
      err_mag_ff   <= err_mag_in;
      diff_neg_ff  <= diff_neg_in;
      diff_mag_ff  <= diff_mag_in;
      dt_ff        <= dt_in;
      prod_ff      <= prod_in;
      dmag_ff      <= dmag_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.drive     = rsp_drive_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

endmodule
